// ----- rtl/c16fd_pkg.sv -----
// shared types, constants and crc helper for the crc16 frame deframer
// used by the controller, the datapath and the top level
`timescale 1ns / 1ps

package c16fd_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 6;
  localparam int POS_W     = 7;
  localparam int CRC_W     = 16;
  localparam int DECL_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_W     = 32;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  localparam logic [POS_W-1:0] POS_MAX      = 7'd127;
  localparam logic [POS_W-1:0] HEADER_BYTES = 7'd8;
  localparam logic [POS_W-1:0] OVERHEAD     = 7'd11;

  // header byte positions
  localparam logic [2:0] HB_START    = 3'd0;
  localparam logic [2:0] HB_RESERVED = 3'd1;
  localparam logic [2:0] HB_DIR      = 3'd2;
  localparam logic [2:0] HB_DEST     = 3'd3;
  localparam logic [2:0] HB_SOURCE   = 3'd4;
  localparam logic [2:0] HB_CMD      = 3'd5;
  localparam logic [2:0] HB_LEN_HI   = 3'd6;
  localparam logic [2:0] HB_LEN_LO   = 3'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START    = 3'd0,
    CFG_RESERVED = 3'd1,
    CFG_DEST     = 3'd2,
    CFG_SOURCE   = 3'd3,
    CFG_END      = 3'd4
  } cfg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic accept;        // input byte taken this cycle
    logic take_last;     // taken byte carries the last flag
    logic load_verdict;  // put the verdict into the output register
    logic load_data;     // put the next payload byte into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;      // output register can take an item this cycle
    logic has_payload;   // verdict accepted with a nonzero length
    logic data_final;    // next data item is the final one
  } dp_status_t;

  function automatic logic [CRC_W-1:0] crc16_update(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/crc16_frame_deframer_top.sv -----
// the verdict loads into the output register after the last byte, then, for an accepted frame
// with a nonzero length, its payload bytes, one per cycle while m_tready is high; input takes
// one byte per cycle in a frame and stalls after the last byte until the last item has loaded
// reset: synchronous rst clears frame state, config registers and the output valid;
// payload ram is not cleared
`timescale 1ns / 1ps

module crc16_frame_deframer_top #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [c16fd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [c16fd_pkg::BYTE_W-1:0]      cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,  // byte_in
  input  logic                              s_tlast,  // last_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // accepted, direction, command, payload_length, data_byte, zero pad
  output logic [c16fd_pkg::OUT_W-1:0]       m_tdata,
  output logic                              m_tuser,  // is_data
  output logic                              m_tlast   // last_result
);

  import c16fd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  c16fd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tlast (s_tlast),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  c16fd_datapath #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .byte_in  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_while_emit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.accept && (cmd.load_verdict || cmd.load_data)))
    else $error("input accepted while results are loading");

  a_stall_after_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.take_last |=> !s_tready)
    else $error("input not stalled after the last byte");

  a_verdict_item: assert property (@(posedge clk) disable iff (rst)
    cmd.load_verdict |=> (m_tvalid && !m_tuser))
    else $error("verdict load did not produce a verdict item");

  a_data_item: assert property (@(posedge clk) disable iff (rst)
    cmd.load_data |=> (m_tvalid && m_tuser && m_tdata[0]))
    else $error("data load did not produce an accepted data item");
`endif

endmodule

// ----- rtl/c16fd_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module c16fd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/c16fd_ctrl.sv -----
// controller fsm: receive bytes, then emit the verdict and the payload items
// depends on c16fd_pkg
`timescale 1ns / 1ps

module c16fd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tlast,
  output logic                  s_tready,
  input  c16fd_pkg::dp_status_t stat,
  output c16fd_pkg::ctrl_cmd_t  cmd
);

  import c16fd_pkg::*;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_VERDICT,
    ST_DATA
  } state_t;

  state_t state;

  always_comb begin
    cmd.accept       = s_tvalid & s_tready;
    cmd.take_last    = s_tvalid & s_tready & s_tlast;
    cmd.load_verdict = (state == ST_VERDICT) & stat.out_free;
    cmd.load_data    = (state == ST_DATA) & stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_RECV;
      s_tready <= 1'b1;
    end else begin
      unique case (state)
        ST_RECV: begin
          if (cmd.take_last) begin
            state    <= ST_VERDICT;
            s_tready <= 1'b0;
          end
        end
        ST_VERDICT: begin
          if (stat.out_free) begin
            if (stat.has_payload) begin
              state <= ST_DATA;
            end else begin
              state    <= ST_RECV;
              s_tready <= 1'b1;
            end
          end
        end
        ST_DATA: begin
          if (stat.out_free && stat.data_final) begin
            state    <= ST_RECV;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_RECV;
          s_tready <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ----- rtl/c16fd_datapath.sv -----
// datapath: header checks, crc, payload buffer, verdict and output register
// depends on c16fd_pkg and c16fd_ram
`timescale 1ns / 1ps

module c16fd_datapath #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [c16fd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [c16fd_pkg::BYTE_W-1:0]        cfg_data,
  input  logic [c16fd_pkg::BYTE_W-1:0]        byte_in,
  input  c16fd_pkg::ctrl_cmd_t                cmd,
  output c16fd_pkg::dp_status_t               stat,
  input  logic                                m_tready,
  output logic                                m_tvalid,
  output logic [c16fd_pkg::OUT_W-1:0]         m_tdata,
  output logic                                m_tuser,
  output logic                                m_tlast
);

  import c16fd_pkg::*;

  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [DECL_W-1:0] MAX_LEN = DECL_W'(MAX_PAYLOAD);

  // configuration
  logic [BYTE_W-1:0] start_code, reserved_code, dest_code, source_code, end_code;

  // frame state
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [CRC_W-1:0]  running_crc, running_crc_next;
  logic [BYTE_W-1:0] header_direction, header_direction_next;
  logic [BYTE_W-1:0] header_command, header_command_next;
  logic [DECL_W-1:0] declared_length, declared_length_next;
  logic [BYTE_W-1:0] crc_high_byte, crc_high_byte_next;
  logic              frame_error, frame_error_next;

  // latched verdict
  logic              v_ok;
  logic [BYTE_W-1:0] v_dir, v_cmd;
  logic [LEN_W-1:0]  v_len;
  logic [LEN_W-1:0]  data_cnt;
  logic [LEN_W:0]    data_cnt_inc;

  // payload ram
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  logic              len_ok;
  logic [POS_W-1:0]  len7;
  logic [POS_W-1:0]  pos_off;
  logic              frame_ok;

  // output register fields
  logic              o_acc;
  logic [BYTE_W-1:0] o_dir, o_cmd, o_data;
  logic [LEN_W-1:0]  o_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code    <= '0;
      reserved_code <= '0;
      dest_code     <= '0;
      source_code   <= '0;
      end_code      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START:    start_code    <= cfg_data;
        CFG_RESERVED: reserved_code <= cfg_data;
        CFG_DEST:     dest_code     <= cfg_data;
        CFG_SOURCE:   source_code   <= cfg_data;
        CFG_END:      end_code      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign len_ok  = (declared_length <= MAX_LEN);
  assign len7    = declared_length[POS_W-1:0];
  assign pos_off = byte_position - HEADER_BYTES;

  always_comb begin
    running_crc_next      = running_crc;
    header_direction_next = header_direction;
    header_command_next   = header_command;
    declared_length_next  = declared_length;
    crc_high_byte_next    = crc_high_byte;
    frame_error_next      = frame_error;
    ram_we                = 1'b0;
    ram_waddr             = pos_off[ADDR_W-1:0];

    priority if (byte_position < HEADER_BYTES) begin
      running_crc_next = crc16_update(running_crc, byte_in);
      unique case (byte_position[2:0])
        HB_START:    if (byte_in != start_code) frame_error_next = 1'b1;
        HB_RESERVED: if (byte_in != reserved_code) frame_error_next = 1'b1;
        HB_DIR:      header_direction_next = byte_in;
        HB_DEST:     if (byte_in != dest_code) frame_error_next = 1'b1;
        HB_SOURCE:   if (byte_in != source_code) frame_error_next = 1'b1;
        HB_CMD:      header_command_next = byte_in;
        HB_LEN_HI:   declared_length_next = {byte_in, 8'h00};
        HB_LEN_LO: begin
          declared_length_next = {declared_length[15:8], byte_in};
          if (declared_length_next > MAX_LEN) frame_error_next = 1'b1;
        end
        default: ;
      endcase
    end else if (!len_ok) begin
      frame_error_next = 1'b1;
    end else if (pos_off < len7) begin
      running_crc_next = crc16_update(running_crc, byte_in);
      ram_we           = cmd.accept;
    end else if (pos_off == len7) begin
      crc_high_byte_next = byte_in;
    end else if (pos_off == len7 + 7'd1) begin
      if ({crc_high_byte, byte_in} != running_crc) frame_error_next = 1'b1;
    end else if (pos_off == len7 + 7'd2) begin
      if (byte_in != end_code) frame_error_next = 1'b1;
    end else begin
      frame_error_next = 1'b1;
    end

    byte_position_next = (byte_position == POS_MAX) ? byte_position
                                                    : byte_position + 7'd1;
  end

  assign frame_ok = !frame_error_next && (declared_length_next <= MAX_LEN) &&
                    (byte_position_next == OVERHEAD + declared_length_next[POS_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      running_crc      <= CRC_INIT;
      header_direction <= '0;
      header_command   <= '0;
      declared_length  <= '0;
      crc_high_byte    <= '0;
      frame_error      <= 1'b0;
    end else if (cmd.take_last) begin
      byte_position    <= '0;
      running_crc      <= CRC_INIT;
      header_direction <= '0;
      header_command   <= '0;
      declared_length  <= '0;
      crc_high_byte    <= '0;
      frame_error      <= 1'b0;
    end else if (cmd.accept) begin
      byte_position    <= byte_position_next;
      running_crc      <= running_crc_next;
      header_direction <= header_direction_next;
      header_command   <= header_command_next;
      declared_length  <= declared_length_next;
      crc_high_byte    <= crc_high_byte_next;
      frame_error      <= frame_error_next;
    end
  end

  // verdict, held through the payload readout
  always_ff @(posedge clk) begin
    if (rst) begin
      v_ok     <= 1'b0;
      data_cnt <= '0;
    end else begin
      if (cmd.take_last) begin
        v_ok     <= frame_ok;
        data_cnt <= '0;
      end else if (cmd.load_data) begin
        data_cnt <= data_cnt_inc[LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_last) begin
      v_dir <= header_direction_next;
      v_cmd <= header_command_next;
      v_len <= declared_length_next[LEN_W-1:0];
    end
  end

  assign data_cnt_inc = {1'b0, data_cnt} + 7'd1;

  // first read goes out with the last byte, then a read ahead per data item but the last
  assign ram_re    = cmd.take_last | (cmd.load_data & ~stat.data_final);
  assign ram_raddr = cmd.take_last ? '0 : data_cnt_inc[ADDR_W-1:0];

  c16fd_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_PAYLOAD)
  ) u_payload_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(byte_in),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign stat.out_free    = !m_tvalid || m_tready;
  assign stat.has_payload = v_ok && (v_len != '0);
  assign stat.data_final  = (data_cnt_inc == {1'b0, v_len});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_verdict || cmd.load_data) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_verdict) begin
      m_tuser <= 1'b0;
      o_acc   <= v_ok;
      o_dir   <= v_ok ? v_dir : '0;
      o_cmd   <= v_ok ? v_cmd : '0;
      o_len   <= v_ok ? v_len : '0;
      o_data  <= '0;
      m_tlast <= !stat.has_payload;
    end else if (cmd.load_data) begin
      m_tuser <= 1'b1;
      o_acc   <= 1'b1;
      o_dir   <= v_dir;
      o_cmd   <= v_cmd;
      o_len   <= v_len;
      o_data  <= ram_rdata;
      m_tlast <= stat.data_final;
    end
  end

  assign m_tdata = {1'b0, o_data, o_len, o_cmd, o_dir, o_acc};

endmodule
